@@ src/dcflm_pkg.sv @@
// ----------------------------------------------------------------------------
// DC-blocked frame level meter: shared definitions
// Field widths, reset constants and the status bundle of the serial units.
// ----------------------------------------------------------------------------
package dcflm_pkg;

    localparam int SAMPLE_W = 16;               // raw PCM sample
    localparam int POLE_W   = 16;               // pole coefficient, unsigned Q0.16
    localparam int Y_W      = 34;               // filter output, signed Q18.16
    localparam int SUM_W    = 40;               // sum of squares
    localparam int LEVEL_W  = 15;               // rms and peak levels
    localparam int INDEX_W  = 32;               // frame index
    localparam int COUNT_W  = 10;               // sample count field
    localparam int QUO_W    = SUM_W + 2;        // quotient of 4 * sum / count
    localparam int ROOT_W   = QUO_W / 2;        // integer root of that quotient
    localparam int OUT_W    = INDEX_W + 2 * LEVEL_W + COUNT_W;

    localparam logic [POLE_W-1:0] POLE_RESET = 16'd62915;

    // Status of a multi-cycle serial unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

@@ src/dcflm_mul.sv @@
// ----------------------------------------------------------------------------
// DC-blocked frame level meter: serial multiplier
// Unsigned 16-bit multiplier times signed 34-bit multiplicand, one multiplier
// bit per cycle, least significant bit first.
// ----------------------------------------------------------------------------
module dcflm_mul (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic        [dcflm_pkg::POLE_W-1:0]     mplier,
    input  logic signed [dcflm_pkg::Y_W-1:0]        mcand,
    output dcflm_pkg::unit_stat_t                   stat,
    output logic signed [dcflm_pkg::Y_W-1:0]        prod_hi,
    output logic        [dcflm_pkg::POLE_W-1:0]     prod_lo
);

    localparam int A_W   = dcflm_pkg::POLE_W;
    localparam int B_W   = dcflm_pkg::Y_W;
    localparam int CNT_W = $clog2(A_W);

    logic signed [B_W:0]   acc_reg, acc_next;
    logic        [A_W-1:0] lo_reg, lo_next;
    logic        [A_W-1:0] mr_reg, mr_next;
    logic signed [B_W-1:0] md_reg, md_next;
    logic        [CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic signed [B_W:0]   addend;
    logic signed [B_W:0]   sum;

    // The partial product stays within twice the multiplicand, so one guard
    // bit is enough.
    assign addend = mr_reg[0] ? {md_reg[B_W-1], md_reg} : '0;
    assign sum    = acc_reg + addend;

    always_comb
    begin
        acc_next  = acc_reg;
        lo_next   = lo_reg;
        mr_next   = mr_reg;
        md_next   = md_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            lo_next   = '0;
            mr_next   = mplier;
            md_next   = mcand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {sum[B_W], sum[B_W:1]};
            lo_next  = {sum[0], lo_reg[A_W-1:1]};
            mr_next  = {1'b0, mr_reg[A_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(A_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        lo_reg  <= lo_next;
        mr_reg  <= mr_next;
        md_reg  <= md_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod_hi   = acc_reg[B_W-1:0];
    assign prod_lo   = lo_reg;

endmodule

@@ src/dcflm_div.sv @@
// ----------------------------------------------------------------------------
// DC-blocked frame level meter: serial divider
// Restoring division of a 42-bit dividend by the frame length, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module dcflm_div #(
    parameter int DIV_W = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [dcflm_pkg::QUO_W-1:0]      dividend,
    input  logic [DIV_W-1:0]                 divisor,
    output dcflm_pkg::unit_stat_t            stat,
    output logic [dcflm_pkg::QUO_W-1:0]      quotient
);

    localparam int Q_W   = dcflm_pkg::QUO_W;
    localparam int CNT_W = $clog2(Q_W);

    logic [Q_W-1:0]   q_reg, q_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    // The remainder stays below the divisor, so the trial value is below
    // twice the divisor and one subtraction settles each bit.
    assign trial = {rem_reg, q_reg[Q_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = trial >= {1'b0, d_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[Q_W-2:0], fits};
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

@@ src/dcflm_sqrt.sv @@
// ----------------------------------------------------------------------------
// DC-blocked frame level meter: serial square root
// Restoring integer square root of a 42-bit value, one root bit (two
// radicand bits) per cycle.
// ----------------------------------------------------------------------------
module dcflm_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [dcflm_pkg::QUO_W-1:0]      radicand,
    output dcflm_pkg::unit_stat_t            stat,
    output logic [dcflm_pkg::ROOT_W-1:0]     root
);

    localparam int Q_W   = dcflm_pkg::QUO_W;
    localparam int R_W   = dcflm_pkg::ROOT_W;
    localparam int REM_W = R_W + 2;
    localparam int CNT_W = $clog2(R_W);

    logic [Q_W-1:0]   rad_reg, rad_next;
    logic [R_W-1:0]   root_reg, root_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             fits;

    assign rem_sh = {rem_reg, rad_reg[Q_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign fits   = rem_sh >= trial;

    always_comb
    begin
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[Q_W-3:0], 2'b00};
            root_next = {root_reg[R_W-2:0], fits};
            rem_next  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(R_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

@@ src/dc_blocked_frame_level_meter_core.sv @@
// ----------------------------------------------------------------------------
// DC-blocked frame level meter
// One-pole DC blocker followed by per-frame RMS, peak and sample count.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  -------------------------------------
// cfg      in         cfg_valid/cfg_ready  cfg_data: pole coefficient (Q0.16)
// s        in         s_tvalid/s_tready    s_tdata: sample, s_tlast: frame end
// m        out        m_tvalid/m_tready    m_tdata: index, rms, peak, count
//
// A sample word is taken only in the idle state, once the last one is through:
// two passes through the 16-step serial multiplier (the filter feedback
// product, then the square) lie between words, and a word that closes a
// frame also waits for its handover. A closed frame is handed to the back
// end, where the divider and then the square root form the result word
// while the next frame's samples are already being filtered.
// The result word waits in an output register; the front end stalls only if
// a second frame closes while the back end still holds the previous one.
// Reset clears control, filter and frame state at once, with no clearing pass.
//
module dc_blocked_frame_level_meter_core #(
    parameter int MAX_FRAME = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcflm_pkg::POLE_W-1:0]      cfg_data,     // [15:0] pole_coefficient
    // Sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dcflm_pkg::SAMPLE_W-1:0]    s_tdata,      // [15:0] sample
    input  logic                              s_tlast,      // frame_end
    // Frame result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dcflm_pkg::OUT_W-1:0]       m_tdata       // [31:0] frame_index,
                                                            // [46:32] rms_level,
                                                            // [61:47] peak_level,
                                                            // [71:62] sample_count
);

    localparam int SAMPLE_W = dcflm_pkg::SAMPLE_W;
    localparam int POLE_W   = dcflm_pkg::POLE_W;
    localparam int Y_W      = dcflm_pkg::Y_W;
    localparam int SUM_W    = dcflm_pkg::SUM_W;
    localparam int LEVEL_W  = dcflm_pkg::LEVEL_W;
    localparam int INDEX_W  = dcflm_pkg::INDEX_W;
    localparam int COUNT_W  = dcflm_pkg::COUNT_W;
    localparam int QUO_W    = dcflm_pkg::QUO_W;
    localparam int ROOT_W   = dcflm_pkg::ROOT_W;
    localparam int OUT_W    = dcflm_pkg::OUT_W;
    localparam int CNT_W    = $clog2(MAX_FRAME + 1);
    localparam int FL_W     = Y_W - POLE_W;             // integer part of y
    localparam int SQ_W     = 2 * SAMPLE_W;             // width of one square

    // Front end: filter and frame statistics for one sample at a time.
    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_FB   = 7'b0000010,
        F_FILT = 7'b0000100,
        F_STAT = 7'b0001000,
        F_SQ   = 7'b0010000,
        F_ACC  = 7'b0100000,
        F_HAND = 7'b1000000
    } fe_state_t;

    // Back end: mean, root and result delivery for one closed frame.
    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIV  = 4'b0010,
        B_SQRT = 4'b0100,
        B_OUT  = 4'b1000
    } be_state_t;

    fe_state_t                   f_state_reg, f_state_next;
    be_state_t                   be_state_reg, be_state_next;

    logic        [POLE_W-1:0]    pole_reg, pole_next;
    logic signed [SAMPLE_W-1:0]  x_reg, x_next;
    logic                        last_reg, last_next;
    logic signed [SAMPLE_W-1:0]  px_reg, px_next;
    logic signed [Y_W-1:0]       py_reg, py_next;
    logic        [SUM_W-1:0]     sum_reg, sum_next;
    logic        [LEVEL_W-1:0]   peak_reg, peak_next;
    logic        [CNT_W-1:0]     cnt_reg, cnt_next;
    logic        [INDEX_W-1:0]   fidx_reg, fidx_next;

    logic        [LEVEL_W-1:0]   be_peak_reg, be_peak_next;
    logic        [CNT_W-1:0]     be_cnt_reg, be_cnt_next;
    logic        [INDEX_W-1:0]   be_idx_reg, be_idx_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic        [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    // Serial unit connections
    logic                        mul_start;
    logic        [POLE_W-1:0]    mul_a;
    logic signed [Y_W-1:0]       mul_b;
    dcflm_pkg::unit_stat_t       mul_stat;
    logic signed [Y_W-1:0]       mul_hi;
    logic        [POLE_W-1:0]    mul_lo;

    logic                        div_start;
    dcflm_pkg::unit_stat_t       div_stat;
    logic        [QUO_W-1:0]     div_q;

    logic                        sqrt_start;
    dcflm_pkg::unit_stat_t       sqrt_stat;
    logic        [ROOT_W-1:0]    sqrt_root;

    // Datapath signals
    logic                        accept;
    logic                        handoff;
    logic                        out_load;
    logic signed [Y_W:0]         fb;
    logic signed [SAMPLE_W:0]    dx;
    logic signed [Y_W+1:0]       y_wide;
    logic        [2:0]           y_top;
    logic signed [Y_W-1:0]       y_sat;
    logic signed [FL_W-1:0]      y_floor;
    logic signed [FL_W-1:0]      y_trunc;
    logic        [FL_W-SAMPLE_W:0] t_top;
    logic signed [SAMPLE_W-1:0]  s16;
    logic        [SAMPLE_W-1:0]  abs16;
    logic        [LEVEL_W-1:0]   mag;
    logic        [SQ_W-1:0]      sq;
    logic        [SUM_W:0]       sum_add;
    logic        [CNT_W-1:0]     cnt_inc;
    logic                        frame_close;
    logic        [ROOT_W:0]      root_inc;
    logic        [ROOT_W-1:0]    rms_wide;
    logic        [LEVEL_W-1:0]   rms;
    logic        [CNT_W+COUNT_W-1:0] cnt_ext;

    assign accept    = s_tvalid & s_tready;
    assign s_tready  = (f_state_reg == F_IDLE);
    assign cfg_ready = 1'b1;
    assign handoff   = (f_state_reg == F_HAND) && (be_state_reg == B_IDLE);

    // ------------------------------------------------------------------
    // Filter: y = (x - prev_x) * 2^16 + round(R * prev_y / 2^16), where the
    // rounding adds one half and takes the floor. The multiplier returns
    // the product split at bit 16, so the rounding is the top low bit.
    // ------------------------------------------------------------------
    assign fb     = {mul_hi[Y_W-1], mul_hi} + (Y_W + 1)'(mul_lo[POLE_W-1]);
    assign dx     = {x_reg[SAMPLE_W-1], x_reg} - {px_reg[SAMPLE_W-1], px_reg};
    assign y_wide = {{(Y_W + 1 - SAMPLE_W - POLE_W){dx[SAMPLE_W]}}, dx, {POLE_W{1'b0}}}
                  + {fb[Y_W], fb};
    assign y_top  = y_wide[Y_W+1:Y_W-1];

    // Saturate to the signed 34-bit range before the value is kept.
    always_comb
    begin
        if (!y_top[2] && (y_top[1:0] != 2'b00))
            y_sat = {1'b0, {(Y_W - 1){1'b1}}};
        else if (y_top[2] && (y_top[1:0] != 2'b11))
            y_sat = {1'b1, {(Y_W - 1){1'b0}}};
        else
            y_sat = y_wide[Y_W-1:0];
    end

    // ------------------------------------------------------------------
    // Statistics value: y truncated toward zero, then saturated to 16 bits.
    // The magnitude used for the square keeps 32768; the peak saturates it.
    // ------------------------------------------------------------------
    assign y_floor = py_reg[Y_W-1:POLE_W];
    assign y_trunc = y_floor + FL_W'(py_reg[Y_W-1] & (|py_reg[POLE_W-1:0]));
    assign t_top   = y_trunc[FL_W-1:SAMPLE_W-1];

    always_comb
    begin
        if (!t_top[FL_W-SAMPLE_W] && (|t_top))
            s16 = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        else if (t_top[FL_W-SAMPLE_W] && !(&t_top))
            s16 = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        else
            s16 = y_trunc[SAMPLE_W-1:0];
    end

    assign abs16 = s16[SAMPLE_W-1] ? (~s16 + 1'b1) : s16;
    assign mag   = abs16[SAMPLE_W-1] ? {LEVEL_W{1'b1}} : abs16[LEVEL_W-1:0];

    // The multiplier is shared: the feedback product starts on acceptance,
    // the square starts once the new output is known.
    assign mul_start = accept | (f_state_reg == F_STAT);
    assign mul_a     = (f_state_reg == F_STAT) ? abs16 : pole_reg;
    assign mul_b     = (f_state_reg == F_STAT) ? {{(Y_W - SAMPLE_W){1'b0}}, abs16} : py_reg;

    // Accumulation; the sum can only saturate with frames of 1024 samples or more.
    assign sq          = {mul_hi[SQ_W-POLE_W-1:0], mul_lo};
    assign sum_add     = {1'b0, sum_reg} + (SUM_W + 1)'(sq);
    assign cnt_inc     = cnt_reg + 1'b1;
    assign frame_close = last_reg || (cnt_inc == CNT_W'(MAX_FRAME));

    // ------------------------------------------------------------------
    // Front end sequencing
    // ------------------------------------------------------------------
    always_comb
    begin
        f_state_next = f_state_reg;
        pole_next    = cfg_valid ? cfg_data : pole_reg;
        x_next       = x_reg;
        last_next    = last_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        sum_next     = sum_reg;
        peak_next    = peak_reg;
        cnt_next     = cnt_reg;
        fidx_next    = fidx_reg;
        be_peak_next = be_peak_reg;
        be_cnt_next  = be_cnt_reg;
        be_idx_next  = be_idx_reg;

        unique case (f_state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    x_next       = signed'(s_tdata);
                    last_next    = s_tlast;
                    f_state_next = F_FB;
                end
            end
            F_FB:
            begin
                if (mul_stat.done)
                    f_state_next = F_FILT;
            end
            F_FILT:
            begin
                px_next      = x_reg;
                py_next      = y_sat;
                f_state_next = F_STAT;
            end
            F_STAT:
            begin
                if (mag > peak_reg)
                    peak_next = mag;
                f_state_next = F_SQ;
            end
            F_SQ:
            begin
                if (mul_stat.done)
                    f_state_next = F_ACC;
            end
            F_ACC:
            begin
                sum_next     = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
                cnt_next     = cnt_inc;
                f_state_next = frame_close ? F_HAND : F_IDLE;
            end
            F_HAND:
            begin
                // The divider takes the sum directly; the rest is kept for
                // the result word.
                if (handoff)
                begin
                    be_peak_next = peak_reg;
                    be_cnt_next  = cnt_reg;
                    be_idx_next  = fidx_reg;
                    sum_next     = '0;
                    peak_next    = '0;
                    cnt_next     = '0;
                    fidx_next    = fidx_reg + 1'b1;
                    f_state_next = F_IDLE;
                end
            end
            default:
            begin
                f_state_next = F_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Back end: rms = round(sqrt(sum / n)) with ties away from zero. That is
    // the largest r with (2r - 1)^2 <= floor(4 * sum / n); with
    // k = isqrt(floor(4 * sum / n)) it equals (k + 1) / 2.
    // ------------------------------------------------------------------
    assign div_start  = handoff;
    assign sqrt_start = (be_state_reg == B_DIV) && div_stat.done;
    assign root_inc   = {1'b0, sqrt_root} + 1'b1;
    assign rms_wide   = root_inc[ROOT_W:1];
    assign rms        = (|rms_wide[ROOT_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}}
                                                      : rms_wide[LEVEL_W-1:0];
    assign cnt_ext    = {{COUNT_W{1'b0}}, be_cnt_reg};
    assign out_load   = (be_state_reg == B_OUT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        be_state_next = be_state_reg;
        unique case (be_state_reg)
            B_IDLE:
            begin
                if (handoff)
                    be_state_next = B_DIV;
            end
            B_DIV:
            begin
                if (div_stat.done)
                    be_state_next = B_SQRT;
            end
            B_SQRT:
            begin
                if (sqrt_stat.done)
                    be_state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_load)
                    be_state_next = B_IDLE;
            end
            default:
            begin
                be_state_next = B_IDLE;
            end
        endcase
    end

    // Output register: the result word waits here until it is taken.
    always_comb
    begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tdata_next  = {cnt_ext[COUNT_W-1:0], be_peak_reg, rms, be_idx_reg};
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_state_reg  <= F_IDLE;
            be_state_reg <= B_IDLE;
            pole_reg     <= dcflm_pkg::POLE_RESET;
            px_reg       <= '0;
            py_reg       <= '0;
            sum_reg      <= '0;
            peak_reg     <= '0;
            cnt_reg      <= '0;
            fidx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            f_state_reg  <= f_state_next;
            be_state_reg <= be_state_next;
            pole_reg     <= pole_next;
            px_reg       <= px_next;
            py_reg       <= py_next;
            sum_reg      <= sum_next;
            peak_reg     <= peak_next;
            cnt_reg      <= cnt_next;
            fidx_reg     <= fidx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        last_reg    <= last_next;
        be_peak_reg <= be_peak_next;
        be_cnt_reg  <= be_cnt_next;
        be_idx_reg  <= be_idx_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Serial units
    // ------------------------------------------------------------------
    dcflm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mplier  (mul_a),
        .mcand   (mul_b),
        .stat    (mul_stat),
        .prod_hi (mul_hi),
        .prod_lo (mul_lo)
    );

    dcflm_div #(
        .DIV_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_reg, 2'b00}),
        .divisor  (cnt_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    dcflm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_q),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

`ifndef SYNTHESIS
    // The shared multiplier is never restarted in the middle of a product.
    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    // A frame is handed over only when the divider has finished the last one.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_sqrt_free: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_stat.busy)
        else $error("square root started while busy");

    // After a handover the next frame starts from empty accumulators.
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        handoff |=> (cnt_reg == '0) && (sum_reg == '0) && (peak_reg == '0))
        else $error("accumulators not cleared after frame close");

    // An open frame never holds a full frame of samples.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (f_state_reg == F_IDLE) |-> (cnt_reg < CNT_W'(MAX_FRAME)))
        else $error("frame count reached its limit without closing");
`endif

endmodule

@@ bench/tb_dc_blocked_frame_level_meter_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the DC-blocked frame level meter
// Sample words go in from a queue through a clocked driver. Each accepted word
// updates a bit-exact copy of the DC blocker and frame statistics, and every
// closed frame is queued as an expected result word. A clocked monitor
// compares the result stream field by field with that queue. The run covers
// a short directed part and several random phases. Each phase sets a pole
// and an idle and stall pattern for the two streams.
// ----------------------------------------------------------------------------
module tb_dc_blocked_frame_level_meter_core;

    localparam int FRAME_LIMIT   = 512;
    localparam int SETTLE_CYCLES = 150;     // quiet time after the last result
    localparam int DRAIN_LIMIT   = 100000;
    localparam int REPORT_LIMIT  = 10;

    localparam longint Y_HIGH  = 64'sd8589934591;
    localparam longint Y_LOW   = -64'sd8589934592;
    localparam longint SUM_CAP = 64'sd1099511627775;

    typedef struct {
        logic signed [dcflm_pkg::SAMPLE_W-1:0] sample;
        logic                                  frame_end;
    } sample_word_t;

    // Same layout as m_tdata, index in the lowest bits.
    typedef struct packed {
        logic [dcflm_pkg::COUNT_W-1:0] count;
        logic [dcflm_pkg::LEVEL_W-1:0] peak;
        logic [dcflm_pkg::LEVEL_W-1:0] rms;
        logic [dcflm_pkg::INDEX_W-1:0] index;
    } frame_stats_t;

    typedef enum {
        WAVE_UNIFORM,
        WAVE_EXTREME,
        WAVE_OFFSET,
        WAVE_QUIET
    } wave_kind_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dcflm_pkg::POLE_W-1:0]   cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [dcflm_pkg::SAMPLE_W-1:0] s_tdata   = '0;    // [15:0] sample
    logic                           s_tlast   = 1'b0;  // frame_end
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [dcflm_pkg::OUT_W-1:0]    m_tdata;           // [31:0] frame_index,
                                                       // [46:32] rms_level,
                                                       // [61:47] peak_level,
                                                       // [71:62] sample_count

    dc_blocked_frame_level_meter_core #(
        .MAX_FRAME (FRAME_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sample_word_t word_q[$];
    frame_stats_t frame_q[$];

    int send_idle_pct   = 0;
    int ready_stall_pct = 0;
    int errors          = 0;
    int words_sent      = 0;
    int frames_checked  = 0;
    int poles_used      = 1;

    // Predictor state: filter memory, frame accumulators and the pole.
    logic [dcflm_pkg::POLE_W-1:0]  pole_q16   = dcflm_pkg::POLE_RESET;
    longint                        last_x     = 0;
    longint                        last_y     = 0;
    longint unsigned               energy     = 0;
    int                            peak_mag   = 0;
    int                            frame_len  = 0;
    logic [dcflm_pkg::INDEX_W-1:0] next_index = '0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Rounded root of energy / n, ties away from zero: the largest r with
    // (2r - 1)^2 * n <= 4 * energy, saturated to the level range.
    function automatic logic [dcflm_pkg::LEVEL_W-1:0] rounded_root_mean(
        input longint unsigned total, input longint unsigned n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned odd;
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            odd = 2 * mid - 1;
            if (odd * odd * n <= 4 * total)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (lo > 32767)
            lo = 32767;
        return lo[dcflm_pkg::LEVEL_W-1:0];
    endfunction

    // Runs one sample through the filter and the frame statistics. Returns 1
    // with the frame result when this sample closes the frame.
    function automatic bit meter_step(input logic signed [dcflm_pkg::SAMPLE_W-1:0] smp,
                                      input logic last, output frame_stats_t res);
        longint x;
        longint feedback;
        longint y;
        longint s;
        longint mag;
        x = smp;
        // Feedback is rounded half up from Q18.32 to Q18.16.
        feedback = (longint'(pole_q16) * last_y + 64'sd32768) >>> 16;
        y = (x - last_x) * 65536 + feedback;
        if (y > Y_HIGH)
            y = Y_HIGH;
        if (y < Y_LOW)
            y = Y_LOW;
        last_x = x;
        last_y = y;

        // Statistics see y truncated toward zero and clamped to 16 bits.
        s = y / 65536;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        mag = (s < 0) ? -s : s;
        if (mag > 32767)
            mag = 32767;

        energy = energy + longint'(s * s);
        if (energy > SUM_CAP)
            energy = SUM_CAP;
        if (mag > peak_mag)
            peak_mag = int'(mag);
        frame_len++;

        res = '0;
        if (!last && frame_len < FRAME_LIMIT)
            return 1'b0;

        res.index = next_index;
        res.rms   = rounded_root_mean(energy, frame_len);
        res.peak  = peak_mag[dcflm_pkg::LEVEL_W-1:0];
        res.count = frame_len[dcflm_pkg::COUNT_W-1:0];
        next_index++;
        energy    = 0;
        peak_mag  = 0;
        frame_len = 0;
        return 1'b1;
    endfunction

    // Sample driver: keeps a word on the bus until it is taken, then offers
    // the next one unless this cycle is chosen to idle.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_word_t word;
        frame_stats_t res;
        bit           offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                word = word_q.pop_front();
                words_sent++;
                if (meter_step(word.sample, word.frame_end, res))
                    frame_q.push_back(res);
                offer = 1'b0;
            end
            if (!offer)
                offer = (word_q.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
            if (offer)
            begin
                s_tdata <= word_q[0].sample;
                s_tlast <= word_q[0].frame_end;
            end
            s_tvalid <= offer;
        end
    end

    // Result monitor: compares each taken result word with the oldest frame
    // the predictor closed.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        frame_stats_t got;
        frame_stats_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (frame_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("Unexpected result word: index %0d rms %0d peak %0d count %0d",
                                 got.index, got.rms, got.peak, got.count);
                end
                else
                begin
                    want = frame_q.pop_front();
                    frames_checked++;
                    if (got.index != want.index || got.rms != want.rms ||
                        got.peak != want.peak || got.count != want.count)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $display("Mismatch: expected index %0d rms %0d peak %0d count %0d",
                                     want.index, want.rms, want.peak, want.count);
                            $display("          actual   index %0d rms %0d peak %0d count %0d",
                                     got.index, got.rms, got.peak, got.count);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
        end
    end

    task automatic push_word(input int value, input bit last);
        sample_word_t word;
        word.sample    = value[dcflm_pkg::SAMPLE_W-1:0];
        word.frame_end = last;
        word_q.push_back(word);
    endtask

    // Waits until every word is taken and every frame result has come back,
    // then leaves the core quiet for a while.
    task automatic settle();
        while (word_q.size() != 0 || s_tvalid || frame_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_pole(input logic [dcflm_pkg::POLE_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pole_q16 = value;
        poles_used++;
        @(negedge clk);
    endtask

    // One frame of len words in a random waveform style. The last word
    // carries close_flag as its frame end marker.
    task automatic queue_frame(input int len, input bit close_flag);
        wave_kind_t kind;
        int         offset;
        int         value;
        int         k;
        kind   = wave_kind_t'($urandom_range(0, 3));
        offset = int'($urandom_range(0, 65535)) - 32768;
        for (k = 0; k < len; k++)
        begin
            unique case (kind)
                WAVE_UNIFORM: value = int'($urandom_range(0, 65535)) - 32768;
                WAVE_EXTREME: value = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 1))
                                                           : -32768 + int'($urandom_range(0, 1));
                WAVE_OFFSET:  value = offset + int'($urandom_range(0, 4000)) - 2000;
                default:      value = int'($urandom_range(0, 64)) - 32;
            endcase
            if (value > 32767)
                value = 32767;
            if (value < -32768)
                value = -32768;
            push_word(value, (k == len - 1) ? close_flag : 1'b0);
        end
    endtask

    // Mostly short frames so results come often, with some longer ones.
    task automatic queue_random_frames(input int n_words);
        int left;
        int len;
        left = n_words;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(25, 120);
            else
                len = $urandom_range(1, 24);
            if (len > left)
                len = left;
            queue_frame(len, 1'b1);
            left -= len;
        end
    endtask

    // The sender pauses at each phase boundary until all results are in,
    // so the pole is only ever written to an idle core.
    task automatic run_phase(input logic [dcflm_pkg::POLE_W-1:0] pole, input int idle_pct,
                             input int stall_pct, input int n_words);
        settle();
        write_pole(pole);
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        queue_random_frames(n_words);
    endtask

    initial
    begin : stimulus
        int waited;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset pole: silence, full-scale steps, the most negative sample.
        push_word(0, 1'b1);
        push_word(32767, 1'b0);
        push_word(-32768, 1'b0);
        push_word(32767, 1'b0);
        push_word(-32768, 1'b1);
        push_word(-32768, 1'b1);
        push_word(1, 1'b0);
        push_word(-1, 1'b0);
        push_word(0, 1'b1);

        // Pole of zero: a full negative step clamps to -32768, so the RMS
        // rounds to 32768 and saturates and the peak saturates as well.
        settle();
        write_pole('0);
        push_word(32767, 1'b1);
        push_word(-32768, 1'b1);
        push_word(-32768, 1'b0);
        push_word(32767, 1'b1);
        push_word(100, 1'b0);
        push_word(100, 1'b1);

        // Pole at its top value: alternating extremes, then a settling tail.
        settle();
        write_pole('1);
        push_word(-32768, 1'b0);
        push_word(32767, 1'b0);
        push_word(-32768, 1'b0);
        push_word(32767, 1'b1);
        push_word(0, 1'b0);
        push_word(0, 1'b1);

        run_phase(dcflm_pkg::POLE_RESET, 0, 0, 170);
        run_phase(16'($urandom_range(1, 65534)), 86, 0, 170);
        run_phase('1, 0, 86, 170);
        run_phase('0, 22, 22, 170);

        // A run longer than the frame limit: the first frame closes on its
        // own at the limit with no end marker, the rest closes on the marker.
        run_phase(16'($urandom_range(1, 65534)), 0, 0, 60);
        queue_frame(600, 1'b1);
        queue_random_frames(40);

        waited = 0;
        while ((word_q.size() != 0 || s_tvalid || frame_q.size() != 0) && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (frame_q.size() != 0)
        begin
            $display("%0d expected frame results never arrived", frame_q.size());
            errors += frame_q.size();
        end

        $display("Sent %0d sample words and checked %0d frame results over %0d pole settings,",
                 words_sent, frames_checked, poles_used);
        $display("with free-running, sender-idle, receiver-stall and mixed phases.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("Timed out waiting for the core");
        $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
src/dcflm_pkg.sv
src/dcflm_mul.sv
src/dcflm_div.sv
src/dcflm_sqrt.sv
src/dc_blocked_frame_level_meter_core.sv
bench/tb_dc_blocked_frame_level_meter_core.sv
